@@ sv/premul_color_matrix_filter_unit_macros.svh @@
// assertion macros shared by the color matrix filter rtl
`ifndef PREMUL_COLOR_MATRIX_FILTER_UNIT_MACROS_SVH
`define PREMUL_COLOR_MATRIX_FILTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define PCMF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCMF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PCMF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PCMF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ sv/pcmf_pkg.sv @@
// shared types and constants for the color matrix filter
`default_nettype none

package pcmf_pkg;

    localparam int CH_W      = 13;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 64;
    localparam int TAPS      = 4;
    localparam int PROD_W    = 30;
    localparam int PAIR_W    = 31;
    localparam int SUM_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [CH_W-1:0]   ch_t;
    typedef logic [ROW_W-1:0]  row_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_ROW     = 2'd0,
        CFG_GREEN_ROW   = 2'd1,
        CFG_BLUE_ROW    = 2'd2,
        CFG_ALPHA_SCALE = 2'd3
    } cfg_idx_t;

    // register reset values
    localparam row_t              RED_ROW_RST     = 64'h0000_0000_0000_1000;
    localparam row_t              GREEN_ROW_RST   = 64'h0000_0000_1000_0000;
    localparam row_t              BLUE_ROW_RST    = 64'h0000_1000_0000_0000;
    localparam logic [COEF_W-1:0] ALPHA_SCALE_RST = 16'h1000;

    // per-stage load strobes for the row datapath
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pcmf_stage_en_t;

endpackage

`default_nettype wire

@@ sv/pcmf_dot.sv @@
// three-stage dot product of one matrix row with a pixel, rounded and floored at zero
`default_nettype none

module pcmf_dot #(
    parameter int FRAC_BITS = 12,
    localparam int Q_W = 31 - FRAC_BITS
) (
    input  wire logic                     aclk,
    input  wire pcmf_pkg::pcmf_stage_en_t en,
    input  wire pcmf_pkg::row_t           row,
    input  wire pcmf_pkg::ch_t            red,
    input  wire pcmf_pkg::ch_t            green,
    input  wire pcmf_pkg::ch_t            blue,
    input  wire pcmf_pkg::ch_t            alpha,
    output logic [Q_W-1:0]                q
);

    localparam logic [pcmf_pkg::SUM_W-1:0] HALF = pcmf_pkg::SUM_W'(1) << (FRAC_BITS - 1);

    pcmf_pkg::ch_t                        chan [pcmf_pkg::TAPS];
    logic signed [pcmf_pkg::PROD_W-1:0]   prod_reg [pcmf_pkg::TAPS];
    logic signed [pcmf_pkg::PAIR_W-1:0]   pair_reg [2];
    logic signed [pcmf_pkg::SUM_W-1:0]    sum;
    logic [pcmf_pkg::SUM_W-1:0]           rnd;
    logic [Q_W-1:0]                       q_reg;

    assign chan[0] = red;
    assign chan[1] = green;
    assign chan[2] = blue;
    assign chan[3] = alpha;

    // stage 1: four coefficient products
    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            for (int k = 0; k < pcmf_pkg::TAPS; k++) begin
                prod_reg[k] <= $signed(row[pcmf_pkg::COEF_W*k +: pcmf_pkg::COEF_W])
                             * $signed({1'b0, chan[k]});
            end
        end
    end

    // stage 2: pair sums
    always_ff @(posedge aclk) begin
        if (en.ld2) begin
            pair_reg[0] <= pcmf_pkg::PAIR_W'(prod_reg[0]) + pcmf_pkg::PAIR_W'(prod_reg[1]);
            pair_reg[1] <= pcmf_pkg::PAIR_W'(prod_reg[2]) + pcmf_pkg::PAIR_W'(prod_reg[3]);
        end
    end

    // stage 3: final sum, round half up, floor at zero
    assign sum = pcmf_pkg::SUM_W'(pair_reg[0]) + pcmf_pkg::SUM_W'(pair_reg[1]);
    assign rnd = unsigned'(sum) + HALF;

    always_ff @(posedge aclk) begin
        if (en.ld3) begin
            q_reg <= sum[pcmf_pkg::SUM_W-1] ? '0 : rnd[pcmf_pkg::SUM_W-2:FRAC_BITS];
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ sv/premul_color_matrix_filter_unit.sv @@
// Color matrix filter for premultiplied RGBA pixels; one pixel per clock unless stalled.
//
// Input beats arrive on the s_ channel (s_valid / s_ready) carrying red, green,
// blue and alpha in unsigned Q1.FRAC_BITS plus a last-pixel flag. Each result beat
// leaves on the m_ channel (m_valid / m_ready): every color is its row of three
// coefficients times red, green, blue plus the row offset times alpha, alpha is
// alpha_scale times alpha, all rounded, floored at zero, alpha capped at 1.0 and
// colors capped at that alpha. The flag is copied through.
// An accepted input beat runs through the four-stage pipeline to m_valid:
// products, pair sums, round and alpha limit, final clamp into the output
// register. Throughput is one beat per cycle while m_ready is high.
// When the receiver holds m_ready low the stages fill one by one; s_ready
// drops only when all four stages hold a beat, and nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity
// matrix with alpha_scale 1.0. Registers are written through cfg_we, cfg_index and
// cfg_wdata, one per cycle, by the user only while no beat is in flight; unenforced.
`default_nettype none

`include "premul_color_matrix_filter_unit_macros.svh"

module premul_color_matrix_filter_unit #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_we,
    input  wire logic [pcmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcmf_pkg::ROW_W-1:0]         cfg_wdata,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [pcmf_pkg::CH_W-1:0]          s_in_red,
    input  wire logic [pcmf_pkg::CH_W-1:0]          s_in_green,
    input  wire logic [pcmf_pkg::CH_W-1:0]          s_in_blue,
    input  wire logic [pcmf_pkg::CH_W-1:0]          s_in_alpha,
    input  wire logic                               s_in_last,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [pcmf_pkg::CH_W-1:0]               m_out_red,
    output logic [pcmf_pkg::CH_W-1:0]               m_out_green,
    output logic [pcmf_pkg::CH_W-1:0]               m_out_blue,
    output logic [pcmf_pkg::CH_W-1:0]               m_out_alpha,
    output logic                                    m_out_last
);

    localparam int Q_W = 31 - FRAC_BITS;
    localparam logic [Q_W-1:0]             ONE_Q = Q_W'(1) << FRAC_BITS;
    localparam logic [pcmf_pkg::SUM_W-1:0] HALF  = pcmf_pkg::SUM_W'(1) << (FRAC_BITS - 1);

    // configuration registers
    pcmf_pkg::row_t                    red_row_reg;
    pcmf_pkg::row_t                    green_row_reg;
    pcmf_pkg::row_t                    blue_row_reg;
    logic [pcmf_pkg::COEF_W-1:0]       alpha_scale_reg;

    // pipeline control
    logic                              v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic                              rdy1, rdy2, rdy3, rdy4;
    logic                              ld4;
    pcmf_pkg::pcmf_stage_en_t          en;

    // alpha path and flag
    logic signed [pcmf_pkg::PROD_W-1:0] a_prod_reg;
    logic [pcmf_pkg::SUM_W-1:0]         a_rnd;
    logic [Q_W-1:0]                     qa_reg;
    logic [Q_W-1:0]                     lim_reg;
    logic                               last1_reg, last2_reg, last3_reg;

    // row results
    logic [Q_W-1:0]                     qr, qg, qb;

    // output register
    pcmf_pkg::ch_t                      red_out_reg, green_out_reg, blue_out_reg;
    pcmf_pkg::ch_t                      alpha_out_reg;
    logic                               last_out_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_row_reg     <= pcmf_pkg::RED_ROW_RST;
            green_row_reg   <= pcmf_pkg::GREEN_ROW_RST;
            blue_row_reg    <= pcmf_pkg::BLUE_ROW_RST;
            alpha_scale_reg <= pcmf_pkg::ALPHA_SCALE_RST;
        end else if (cfg_we) begin
            unique case (pcmf_pkg::cfg_idx_t'(cfg_index))
                pcmf_pkg::CFG_RED_ROW:     red_row_reg     <= cfg_wdata;
                pcmf_pkg::CFG_GREEN_ROW:   green_row_reg   <= cfg_wdata;
                pcmf_pkg::CFG_BLUE_ROW:    blue_row_reg    <= cfg_wdata;
                pcmf_pkg::CFG_ALPHA_SCALE: alpha_scale_reg <= cfg_wdata[pcmf_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when it is empty or its beat moves on
    assign rdy4 = !m_valid_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.ld1 = s_valid && rdy1;
    assign en.ld2 = v1_reg && rdy2;
    assign en.ld3 = v2_reg && rdy3;
    assign ld4    = v3_reg && rdy4;

    assign s_ready = rdy1;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_valid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) m_valid_reg <= v3_reg;
        end
    end

    // color rows
    pcmf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_red (
        .aclk  (aclk),
        .en    (en),
        .row   (red_row_reg),
        .red   (s_in_red),
        .green (s_in_green),
        .blue  (s_in_blue),
        .alpha (s_in_alpha),
        .q     (qr)
    );

    pcmf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_green (
        .aclk  (aclk),
        .en    (en),
        .row   (green_row_reg),
        .red   (s_in_red),
        .green (s_in_green),
        .blue  (s_in_blue),
        .alpha (s_in_alpha),
        .q     (qg)
    );

    pcmf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_blue (
        .aclk  (aclk),
        .en    (en),
        .row   (blue_row_reg),
        .red   (s_in_red),
        .green (s_in_green),
        .blue  (s_in_blue),
        .alpha (s_in_alpha),
        .q     (qb)
    );

    // alpha: scale, round, then limit to one
    assign a_rnd = unsigned'(pcmf_pkg::SUM_W'(a_prod_reg)) + HALF;

    always_ff @(posedge aclk) begin
        if (en.ld1) begin
            a_prod_reg <= $signed(alpha_scale_reg) * $signed({1'b0, s_in_alpha});
            last1_reg  <= s_in_last;
        end
        if (en.ld2) begin
            qa_reg    <= a_prod_reg[pcmf_pkg::PROD_W-1] ? '0
                                                        : a_rnd[pcmf_pkg::SUM_W-2:FRAC_BITS];
            last2_reg <= last1_reg;
        end
        if (en.ld3) begin
            lim_reg   <= (qa_reg < ONE_Q) ? qa_reg : ONE_Q;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: clamp colors to alpha into the output register
    always_ff @(posedge aclk) begin
        if (ld4) begin
            red_out_reg   <= (qr > lim_reg) ? lim_reg[pcmf_pkg::CH_W-1:0] : qr[pcmf_pkg::CH_W-1:0];
            green_out_reg <= (qg > lim_reg) ? lim_reg[pcmf_pkg::CH_W-1:0] : qg[pcmf_pkg::CH_W-1:0];
            blue_out_reg  <= (qb > lim_reg) ? lim_reg[pcmf_pkg::CH_W-1:0] : qb[pcmf_pkg::CH_W-1:0];
            alpha_out_reg <= lim_reg[pcmf_pkg::CH_W-1:0];
            last_out_reg  <= last3_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = red_out_reg;
    assign m_out_green = green_out_reg;
    assign m_out_blue  = blue_out_reg;
    assign m_out_alpha = alpha_out_reg;
    assign m_out_last  = last_out_reg;

    // checks
    `PCMF_ASSERT_IMP(a_full_on_stall, aclk, aresetn, !s_ready,
        v1_reg && v2_reg && v3_reg && m_valid_reg, "input stalled with a free stage")
    `PCMF_ASSERT_IMP(a_lim_le_one, aclk, aresetn, v3_reg, lim_reg <= ONE_Q,
        "alpha limit above one")
    `PCMF_ASSERT_NXT(a_stage3_holds, aclk, aresetn, v3_reg && !rdy4,
        v3_reg && $stable(lim_reg) && $stable(qr), "stage 3 beat changed while stalled")
    `PCMF_ASSERT_IMP(a_color_le_alpha, aclk, aresetn, m_valid_reg && (FRAC_BITS < 13),
        (red_out_reg <= alpha_out_reg) && (green_out_reg <= alpha_out_reg)
        && (blue_out_reg <= alpha_out_reg), "color above alpha")

endmodule

`default_nettype wire
